// ----- sv/pmst_pkg.sv -----
package pmst_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int WEIGHT_BITS  = 16;
    localparam int VTX_BITS     = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int COST_BITS    = 21;

    typedef logic [VTX_BITS-1:0]    t_vtx;
    typedef logic [CNT_BITS-1:0]    t_cnt;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [COST_BITS-1:0]   t_cost;
    typedef logic [MAX_VERTICES-1:0][WEIGHT_BITS-1:0] t_row;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_SOLVE = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_RD_S,
        ST_LD_WR_S,
        ST_LD_RD_D,
        ST_LD_WR_D,
        ST_SV_RD,
        ST_SV_UPD,
        ST_SV_SCAN,
        ST_SV_EMIT
    } t_state;

endpackage

// ----- sv/prim_minimum_spanning_tree_core.sv -----
// Minimum spanning tree engine over a symmetric adjacency matrix held in a row-wide
// synchronous memory (one row of all vertex weights per entry, one read and one write
// port). In a load, the two mirrored entries are each updated by a row read and a row
// write. A clear only resets the row valid bits: each row carries a valid bit that
// makes an unwritten row read as zero, so no clearing pass is needed after reset. A
// solve grows the tree from vertex 0 and, per tree edge, does a row read, a step that
// relaxes all candidate keys in parallel, a scan of the keys of the n active vertices
// one vertex at a time for the smallest, and a step that hands the edge to the output
// register once that register is free. Input is held off until the solve has handed
// over its last result; the output register lets the next transfer in while that
// result still waits to be taken.
module prim_minimum_spanning_tree_core
    import pmst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [4:0]  i_src_vertex,
    input  logic [4:0]  i_dst_vertex,
    input  logic [15:0] i_edge_weight,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_edge_from,
    output logic [4:0]  o_edge_to,
    output logic [15:0] o_edge_cost,
    output logic        o_edge_valid,
    output logic [20:0] o_tree_cost,
    output logic        o_spanning,
    output logic        o_last
);

    t_row mem [MAX_VERTICES];
    t_row r_rdata;
    logic r_rd_ok;
    logic mem_we;
    t_vtx mem_waddr;
    t_vtx mem_raddr;
    t_row mem_wdata;
    t_row row_merged;

    t_state r_state, n_state;
    logic [5:0] r_vcount, n_vcount;
    logic [MAX_VERTICES-1:0] r_row_ok, n_row_ok;
    logic r_o_valid, n_o_valid;

    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [MAX_VERTICES-1:0] r_kval, n_kval;
    t_weight r_key [MAX_VERTICES];
    t_weight n_key [MAX_VERTICES];
    t_vtx r_par [MAX_VERTICES];
    t_vtx n_par [MAX_VERTICES];
    t_vtx r_v, n_v;
    t_vtx r_idx, n_idx;
    logic r_found, n_found;
    t_weight r_bkey, n_bkey;
    t_vtx r_bpar, n_bpar;
    t_vtx r_bj, n_bj;
    t_cnt r_edges, n_edges;
    t_cnt r_n, n_n;
    t_cost r_cost, n_cost;
    t_vtx r_ld_s, n_ld_s;
    t_vtx r_ld_d, n_ld_d;
    t_weight r_ld_w, n_ld_w;
    t_vtx r_p_from, n_p_from;
    t_vtx r_p_to, n_p_to;
    t_weight r_p_cost, n_p_cost;
    logic r_p_valid, n_p_valid;
    logic r_p_span, n_p_span;
    logic r_p_last, n_p_last;
    logic [4:0] r_o_from, n_o_from;
    logic [4:0] r_o_to, n_o_to;
    logic [15:0] r_o_cost, n_o_cost;
    logic r_o_evalid, n_o_evalid;
    logic [20:0] r_o_total, n_o_total;
    logic r_o_span, n_o_span;
    logic r_o_last, n_o_last;

    t_cnt act_n;
    logic slot_free;
    logic c_ok;
    logic c_better;
    logic s_found;
    t_weight s_bkey;
    t_vtx s_bpar;
    t_vtx s_bj;
    t_cnt inc_edges;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
        r_rd_ok <= r_row_ok[mem_raddr];
    end

    assign row_merged = r_rd_ok ? r_rdata : '0;

    always_comb begin
        if (r_vcount == 6'd0) begin
            act_n = CNT_BITS'(1);
        end else if (32'(r_vcount) > MAX_VERTICES) begin
            act_n = CNT_BITS'(MAX_VERTICES);
        end else begin
            act_n = CNT_BITS'(r_vcount);
        end
    end

    assign slot_free = !r_o_valid || i_ready;

    assign c_ok     = !r_visited[r_idx] && r_kval[r_idx];
    assign c_better = c_ok && (!r_found || (r_key[r_idx] < r_bkey) ||
                      ((r_key[r_idx] == r_bkey) && (r_par[r_idx] < r_bpar)));
    assign s_found  = r_found || c_ok;
    assign s_bkey   = c_better ? r_key[r_idx] : r_bkey;
    assign s_bpar   = c_better ? r_par[r_idx] : r_bpar;
    assign s_bj     = c_better ? r_idx : r_bj;
    assign inc_edges = r_edges + CNT_BITS'(1);

    always_comb begin
        n_state   = r_state;
        n_vcount  = i_cfg_we ? i_cfg_data : r_vcount;
        n_row_ok  = r_row_ok;
        n_o_valid = i_ready ? 1'b0 : r_o_valid;
        n_visited = r_visited;
        n_kval    = r_kval;
        n_key     = r_key;
        n_par     = r_par;
        n_v       = r_v;
        n_idx     = r_idx;
        n_found   = r_found;
        n_bkey    = r_bkey;
        n_bpar    = r_bpar;
        n_bj      = r_bj;
        n_edges   = r_edges;
        n_n       = r_n;
        n_cost    = r_cost;
        n_ld_s    = r_ld_s;
        n_ld_d    = r_ld_d;
        n_ld_w    = r_ld_w;
        n_p_from  = r_p_from;
        n_p_to    = r_p_to;
        n_p_cost  = r_p_cost;
        n_p_valid = r_p_valid;
        n_p_span  = r_p_span;
        n_p_last  = r_p_last;
        n_o_from  = r_o_from;
        n_o_to    = r_o_to;
        n_o_cost  = r_o_cost;
        n_o_evalid = r_o_evalid;
        n_o_total = r_o_total;
        n_o_span  = r_o_span;
        n_o_last  = r_o_last;
        mem_we    = 1'b0;
        mem_waddr = r_ld_s;
        mem_raddr = r_v;
        mem_wdata = row_merged;
        o_ready   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    priority if (i_req_type == REQ_LOAD) begin
                        n_ld_s = VTX_BITS'(i_src_vertex);
                        n_ld_d = VTX_BITS'(i_dst_vertex);
                        n_ld_w = WEIGHT_BITS'(i_edge_weight);
                        if ((32'(i_src_vertex) < MAX_VERTICES) &&
                            (32'(i_dst_vertex) < MAX_VERTICES)) begin
                            n_state = ST_LD_RD_S;
                        end
                    end else if (i_req_type == REQ_SOLVE) begin
                        n_visited = '0;
                        n_visited[0] = 1'b1;
                        n_kval  = '0;
                        n_cost  = '0;
                        n_edges = '0;
                        n_n     = act_n;
                        n_v     = '0;
                        if (act_n == CNT_BITS'(1)) begin
                            n_p_from  = '0;
                            n_p_to    = '0;
                            n_p_cost  = '0;
                            n_p_valid = 1'b0;
                            n_p_span  = 1'b1;
                            n_p_last  = 1'b1;
                            n_state   = ST_SV_EMIT;
                        end else begin
                            n_state = ST_SV_RD;
                        end
                    end else if (i_req_type == REQ_CLEAR) begin
                        n_row_ok = '0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_LD_RD_S: begin
                mem_raddr = r_ld_s;
                n_state   = ST_LD_WR_S;
            end
            ST_LD_WR_S: begin
                mem_we            = 1'b1;
                mem_waddr         = r_ld_s;
                mem_wdata[r_ld_d] = r_ld_w;
                n_row_ok[r_ld_s]  = 1'b1;
                n_state           = ST_LD_RD_D;
            end
            ST_LD_RD_D: begin
                mem_raddr = r_ld_d;
                n_state   = ST_LD_WR_D;
            end
            ST_LD_WR_D: begin
                mem_we            = 1'b1;
                mem_waddr         = r_ld_d;
                mem_wdata[r_ld_s] = r_ld_w;
                n_row_ok[r_ld_d]  = 1'b1;
                n_state           = ST_IDLE;
            end
            ST_SV_RD: begin
                mem_raddr = r_v;
                n_state   = ST_SV_UPD;
            end
            ST_SV_UPD: begin
                for (int j = 0; j < MAX_VERTICES; j++) begin
                    if (!r_visited[j] && (row_merged[j] != '0) &&
                        (!r_kval[j] || (row_merged[j] < r_key[j]) ||
                         ((row_merged[j] == r_key[j]) && (r_v < r_par[j])))) begin
                        n_kval[j] = 1'b1;
                        n_key[j]  = row_merged[j];
                        n_par[j]  = r_v;
                    end
                end
                n_idx   = '0;
                n_found = 1'b0;
                n_state = ST_SV_SCAN;
            end
            ST_SV_SCAN: begin
                n_found = s_found;
                n_bkey  = s_bkey;
                n_bpar  = s_bpar;
                n_bj    = s_bj;
                if (CNT_BITS'(r_idx) == (r_n - CNT_BITS'(1))) begin
                    n_state = ST_SV_EMIT;
                    if (!s_found) begin
                        n_p_from  = '0;
                        n_p_to    = '0;
                        n_p_cost  = '0;
                        n_p_valid = 1'b0;
                        n_p_span  = 1'b0;
                        n_p_last  = 1'b1;
                    end else begin
                        n_visited[s_bj] = 1'b1;
                        n_cost    = r_cost + COST_BITS'(s_bkey);
                        n_edges   = inc_edges;
                        n_p_from  = s_bpar;
                        n_p_to    = s_bj;
                        n_p_cost  = s_bkey;
                        n_p_valid = 1'b1;
                        n_p_span  = (inc_edges == (r_n - CNT_BITS'(1)));
                        n_p_last  = (inc_edges == (r_n - CNT_BITS'(1)));
                    end
                end else begin
                    n_idx = r_idx + VTX_BITS'(1);
                end
            end
            ST_SV_EMIT: begin
                if (slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_from   = 5'(r_p_from);
                    n_o_to     = 5'(r_p_to);
                    n_o_cost   = 16'(r_p_cost);
                    n_o_evalid = r_p_valid;
                    n_o_total  = r_cost;
                    n_o_span   = r_p_span;
                    n_o_last   = r_p_last;
                    n_v        = r_p_to;
                    n_state    = r_p_last ? ST_IDLE : ST_SV_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vcount  <= 6'd32;
            r_row_ok  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vcount  <= n_vcount;
            r_row_ok  <= n_row_ok;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_visited  <= n_visited;
        r_kval     <= n_kval;
        r_key      <= n_key;
        r_par      <= n_par;
        r_v        <= n_v;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_bkey     <= n_bkey;
        r_bpar     <= n_bpar;
        r_bj       <= n_bj;
        r_edges    <= n_edges;
        r_n        <= n_n;
        r_cost     <= n_cost;
        r_ld_s     <= n_ld_s;
        r_ld_d     <= n_ld_d;
        r_ld_w     <= n_ld_w;
        r_p_from   <= n_p_from;
        r_p_to     <= n_p_to;
        r_p_cost   <= n_p_cost;
        r_p_valid  <= n_p_valid;
        r_p_span   <= n_p_span;
        r_p_last   <= n_p_last;
        r_o_from   <= n_o_from;
        r_o_to     <= n_o_to;
        r_o_cost   <= n_o_cost;
        r_o_evalid <= n_o_evalid;
        r_o_total  <= n_o_total;
        r_o_span   <= n_o_span;
        r_o_last   <= n_o_last;
    end

    assign o_valid      = r_o_valid;
    assign o_edge_from  = r_o_from;
    assign o_edge_to    = r_o_to;
    assign o_edge_cost  = r_o_cost;
    assign o_edge_valid = r_o_evalid;
    assign o_tree_cost  = r_o_total;
    assign o_spanning   = r_o_span;
    assign o_last       = r_o_last;

`ifndef SYNTHESIS
    a_edgeless_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_edge_valid) |-> o_last)
        else $error("edgeless result without last");

    a_span_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_spanning) |-> o_last)
        else $error("spanning flag on a result that is not last");

    a_root_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SV_SCAN) |-> r_visited[0])
        else $error("root vertex lost from the tree during a scan");

    a_span_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SV_EMIT) && r_p_span) |-> (r_edges == (r_n - CNT_BITS'(1))))
        else $error("spanning reported before all vertices were reached");
`endif

endmodule

// ----- sim/tb_prim_minimum_spanning_tree_core.sv -----
module tb_prim_minimum_spanning_tree_core;
    import pmst_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_vtx    edge_from;
        t_vtx    edge_to;
        t_weight edge_cost;
        logic    edge_valid;
        t_cost   tree_cost;
        logic    spanning;
        logic    last;
    } t_mst_result;

    class mst_scoreboard;
        t_weight     weight_mat [MAX_VERTICES][MAX_VERTICES];
        logic [5:0]  count_reg;
        t_mst_result tree_edges_q [$];
        int          errors;

        function new();
            clear_matrix();
            count_reg = 6'd32;
            errors = 0;
        endfunction

        function void clear_matrix();
            foreach (weight_mat[i, j]) weight_mat[i][j] = '0;
        endfunction

        function void set_count(logic [5:0] v);
            count_reg = v;
        endfunction

        function int active_count();
            if (count_reg < 1) return 1;
            if (count_reg > MAX_VERTICES) return MAX_VERTICES;
            return int'(count_reg);
        endfunction

        function int pending();
            return tree_edges_q.size();
        endfunction

        function void push_edge(int f, int t, t_weight c, logic e, t_cost sum, logic s, logic l);
            t_mst_result r;
            r = '{t_vtx'(f), t_vtx'(t), c, e, sum, s, l};
            tree_edges_q.push_back(r);
        endfunction

        function void grow_tree();
            int n, edges, br, bc;
            logic [MAX_VERTICES-1:0] seen;
            t_cost sum;
            t_weight best;
            bit found;
            n = active_count();
            seen = 1;
            sum = '0;
            edges = 0;
            if (n == 1) begin
                push_edge(0, 0, '0, 1'b0, '0, 1'b1, 1'b1);
                return;
            end
            while (edges < n - 1) begin
                found = 1'b0;
                best = '0;
                br = 0;
                bc = 0;
                for (int i = 0; i < n; i++) begin
                    if (!seen[i]) continue;
                    for (int j = 0; j < n; j++) begin
                        if (seen[j] || weight_mat[i][j] == '0) continue;
                        if (!found || weight_mat[i][j] < best) begin
                            found = 1'b1;
                            best = weight_mat[i][j];
                            br = i;
                            bc = j;
                        end
                    end
                end
                if (!found) begin
                    push_edge(0, 0, '0, 1'b0, sum, 1'b0, 1'b1);
                    return;
                end
                seen[bc] = 1'b1;
                sum = sum + t_cost'(best);
                edges++;
                push_edge(br, bc, best, 1'b1, sum, edges == n - 1, edges == n - 1);
            end
        endfunction

        function void note_input(logic [1:0] req, t_vtx s, t_vtx d, t_weight w);
            case (req)
                REQ_LOAD: begin
                    weight_mat[s][d] = w;
                    weight_mat[d][s] = w;
                end
                REQ_SOLVE: grow_tree();
                REQ_CLEAR: clear_matrix();
                default: ;
            endcase
        endfunction

        task report(string msg);
            if (errors < 40) $display("[tb] mismatch: %s", msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(t_mst_result got);
            t_mst_result want;
            if (tree_edges_q.size() == 0) begin
                report("result transfer with no tree edge expected");
                return;
            end
            want = tree_edges_q.pop_front();
            compare_field("edge_from", got.edge_from, want.edge_from);
            compare_field("edge_to", got.edge_to, want.edge_to);
            compare_field("edge_cost", got.edge_cost, want.edge_cost);
            compare_field("edge_valid", got.edge_valid, want.edge_valid);
            compare_field("tree_cost", got.tree_cost, want.tree_cost);
            compare_field("spanning", got.spanning, want.spanning);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [5:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [4:0]  i_src_vertex = '0;
    logic [4:0]  i_dst_vertex = '0;
    logic [15:0] i_edge_weight = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [4:0]  o_edge_from;
    logic [4:0]  o_edge_to;
    logic [15:0] o_edge_cost;
    logic        o_edge_valid;
    logic [20:0] o_tree_cost;
    logic        o_spanning;
    logic        o_last;

    mst_scoreboard sb;
    t_mst_result   out_item;
    bit            gaps_on = 1'b0;
    bit            hold_req = 1'b0;
    int            items_sent = 0;

    prim_minimum_spanning_tree_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_src_vertex  (i_src_vertex),
        .i_dst_vertex  (i_dst_vertex),
        .i_edge_weight (i_edge_weight),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_edge_from   (o_edge_from),
        .o_edge_to     (o_edge_to),
        .o_edge_cost   (o_edge_cost),
        .o_edge_valid  (o_edge_valid),
        .o_tree_cost   (o_tree_cost),
        .o_spanning    (o_spanning),
        .o_last        (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_weight rand_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return t_weight'($urandom_range(1, 8));
        if (r < 9) return t_weight'($urandom_range(1, 65535));
        return (r[0]) ? 16'hFFFF : 16'd1;
    endfunction

    task automatic send(logic [1:0] req, t_vtx s, t_vtx d, t_weight w);
        int g;
        g = gaps_on ? idle_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_src_vertex  <= s;
        i_dst_vertex  <= d;
        i_edge_weight <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(req, s, d, w);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(logic [5:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_count(v);
    endtask

    task automatic random_noise();
        t_vtx v;
        v = t_vtx'($urandom);
        case ($urandom_range(0, 5))
            0: send(REQ_UNKNOWN, t_vtx'($urandom), t_vtx'($urandom), t_weight'($urandom));
            1: send(REQ_LOAD, t_vtx'($urandom), t_vtx'($urandom), t_weight'($urandom));
            2: send(REQ_LOAD, v, v, rand_weight());
            3: send(REQ_LOAD, t_vtx'($urandom), t_vtx'($urandom), '0);
            4: send(REQ_CLEAR, t_vtx'($urandom), t_vtx'($urandom), t_weight'($urandom));
            default: send(REQ_SOLVE, t_vtx'($urandom), t_vtx'($urandom), t_weight'($urandom));
        endcase
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            out_item = '{o_edge_from, o_edge_to, o_edge_cost, o_edge_valid,
                         o_tree_cost, o_spanning, o_last};
            sb.check_result(out_item);
        end
    end

    initial begin
        #36000000;
        $display("[prim_minimum_spanning_tree_core] ERROR");
        $finish;
    end

    initial begin
        int phase, n, skip_v;
        logic [5:0] cnt_val;
        t_vtx a, b;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from the reset count of 32 and an empty matrix.
        gaps_on = 1'b0;
        send(REQ_SOLVE, 5'd0, 5'd0, 16'd0);
        send(REQ_LOAD, 5'd31, 5'd30, 16'hFFFF);
        send(REQ_LOAD, 5'd0, 5'd31, 16'd1);
        send(REQ_LOAD, 5'd0, 5'd0, 16'd5);
        send(REQ_LOAD, 5'd5, 5'd6, 16'd9);
        send(REQ_LOAD, 5'd6, 5'd5, 16'd0);
        send(REQ_SOLVE, 5'd31, 5'd31, 16'hFFFF);
        wait_idle();
        set_vertex_count(6'd0);
        send(REQ_SOLVE, 5'd0, 5'd0, 16'd0);
        wait_idle();
        set_vertex_count(6'd1);
        send(REQ_SOLVE, 5'd0, 5'd0, 16'd0);
        wait_idle();
        set_vertex_count(6'd3);
        send(REQ_LOAD, 5'd0, 5'd1, 16'd7);
        send(REQ_LOAD, 5'd2, 5'd0, 16'd7);
        send(REQ_LOAD, 5'd1, 5'd2, 16'd7);
        send(REQ_LOAD, 5'd2, 5'd5, 16'd1);
        send(REQ_UNKNOWN, 5'd31, 5'd31, 16'hFFFF);
        send(REQ_SOLVE, 5'd0, 5'd0, 16'd0);
        send(REQ_LOAD, 5'd0, 5'd2, 16'd0);
        send(REQ_LOAD, 5'd1, 5'd2, 16'd0);
        send(REQ_SOLVE, 5'd0, 5'd0, 16'd0);
        send(REQ_CLEAR, 5'd31, 5'd31, 16'hFFFF);
        send(REQ_SOLVE, 5'd0, 5'd0, 16'd0);
        wait_idle();
        set_vertex_count(6'd63);
        send(REQ_LOAD, 5'd31, 5'd31, 16'hFFFF);
        send(REQ_SOLVE, 5'd0, 5'd0, 16'd0);

        phase = 0;
        while (items_sent < 190) begin
            wait_idle();
            if (phase == 0) begin
                cnt_val = 6'd32;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        case ($urandom_range(0, 5))
                            0: cnt_val = 6'd0;
                            1: cnt_val = 6'd1;
                            2: cnt_val = 6'd2;
                            3: cnt_val = 6'd32;
                            4: cnt_val = 6'd33;
                            default: cnt_val = 6'd63;
                        endcase
                    end
                    3: cnt_val = 6'($urandom_range(20, 31));
                    default: cnt_val = 6'($urandom_range(2, 10));
                endcase
            end
            set_vertex_count(cnt_val);
            n = sb.active_count();
            gaps_on = (phase == 0) || ($urandom_range(0, 3) != 0);

            if (phase == 0 || $urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 1)) send(REQ_CLEAR, t_vtx'($urandom), t_vtx'($urandom),
                                               t_weight'($urandom));
                skip_v = (n > 1 && phase != 0 && $urandom_range(0, 6) == 0) ?
                         $urandom_range(1, n - 1) : 0;
                for (int v = 1; v < n; v++) begin
                    if (v == skip_v) continue;
                    a = t_vtx'(v);
                    b = t_vtx'($urandom_range(0, v - 1));
                    if ($urandom_range(0, 1)) send(REQ_LOAD, a, b, rand_weight());
                    else send(REQ_LOAD, b, a, rand_weight());
                end
                repeat ($urandom_range(0, n)) send(REQ_LOAD, t_vtx'($urandom_range(0, n - 1)),
                                                   t_vtx'($urandom_range(0, n - 1)),
                                                   rand_weight());
                repeat ($urandom_range(0, 2)) random_noise();
                // The first phase stalls the result side long enough to back up input.
                if (phase == 0) hold_req = 1'b1;
                send(REQ_SOLVE, t_vtx'($urandom), t_vtx'($urandom), t_weight'($urandom));
                if (phase == 0 || $urandom_range(0, 1)) begin
                    repeat ($urandom_range(1, 3)) begin
                        a = t_vtx'($urandom_range(0, n - 1));
                        b = t_vtx'($urandom_range(0, n - 1));
                        send(REQ_LOAD, a, b, ($urandom_range(0, 2) == 0) ? '0 : rand_weight());
                    end
                    if (phase == 0 || $urandom_range(0, 1)) wait_idle();
                    send(REQ_SOLVE, t_vtx'($urandom), t_vtx'($urandom), t_weight'($urandom));
                end
            end else begin
                repeat ($urandom_range(4, 12)) random_noise();
            end
            phase++;
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[prim_minimum_spanning_tree_core] OK");
        end else begin
            $display("[prim_minimum_spanning_tree_core] ERROR");
        end
        $finish;
    end

endmodule
